// ===== rtl/core/hcbp_pkg.sv =====
// Package for the Huffman code bit packer: field widths, table sizes,
// operation codes and the table access structs. No dependencies.
package hcbp_pkg;

    // Block sizes
    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_COUNT  = 256;
    localparam int BYTE_BITS     = 8;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;

    // Derived sizes
    localparam int CAP_BITS = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int SYM_AW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W    = CAP_BITS + BYTE_BITS - 1;
    localparam int CNT_W    = $clog2(ACC_W + 1);
    localparam int BPOS_W   = $clog2(BYTE_BITS);

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [CNT_W-1:0] t_cnt;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    // Table write request
    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [CODE_W-1:0] bits;
    } t_tbl_wr;

    // Table read response (registered)
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_tbl_rd;

endpackage

// ===== rtl/core/hcbp_if.sv =====
// Valid/ready channel interfaces for the input items and the result bytes.
// Depends on hcbp_pkg for the field widths.
interface hcbp_in_if import hcbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;

    modport source (output valid, op, symbol, code_length, code_bits, input ready);
    modport sink   (input valid, op, symbol, code_length, code_bits, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 error;
    logic                 last;

    modport source (output valid, out_byte, error, last, input ready);
    modport sink   (input valid, out_byte, error, last, output ready);
endinterface

// ===== rtl/core/huffman_code_bit_packer.sv =====
// Huffman code bit packer: table-driven encoder with LSB-first byte output.
// Depends on hcbp_pkg, hcbp_if and hcbp_table.
//
// Usage:
//   i_item carries one transaction per item: op load writes a table entry,
//   op encode appends a symbol's code to the bit accumulator, op flush pushes
//   out the partial byte zero-padded. o_res carries one byte per transaction,
//   with error set for an encode of an unloaded symbol and last set on the
//   final result of each input item.
//   An item's first result reaches the output register through the lookup
//   stage (error, flush) or through the lookup stage and the accumulator
//   (encoded bytes). The table read is pipelined, so an item enters every
//   cycle while the packer takes the lookup stage; the packer absorbs an item
//   and then sends its full bytes one at a time before the next item, and
//   loads and byte-free encodes need only the absorb step.
//   Reset clears all valid marks, the accumulator and both pipeline stages
//   at once; table contents are not cleared and need no pass.
//   A stalled receiver holds the output register; the packer stops at its next
//   byte, error or flush, and items are taken until the lookup stage is full.
module huffman_code_bit_packer import hcbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbp_in_if.sink    i_item,
    hcbp_out_if.source o_res
);

    // lookup stage
    logic            r_s1_vld;
    logic [OP_W-1:0] r_s1_op;
    logic            in_accept;
    logic            s1_take;
    t_tbl_wr         tbl_wr;
    t_tbl_rd         tbl_rd;
    logic [LEN_W-1:0] load_len;

    // packer state
    t_acc r_acc;
    t_acc n_acc;
    t_cnt r_cnt;
    t_cnt n_cnt;

    // output register
    logic                 r_out_vld;
    logic [BYTE_BITS-1:0] r_out_byte;
    logic                 r_out_err;
    logic                 r_out_last;
    logic                 out_free;
    logic                 emit;
    logic [BYTE_BITS-1:0] emit_byte;
    logic                 emit_err;
    logic                 emit_last;

    // code masked to its length
    logic [CODE_W-1:0] code_masked;
    t_acc              code_ext;

    assign out_free  = !r_out_vld || o_res.ready;
    assign in_accept = i_item.valid && i_item.ready;
    assign i_item.ready = !r_s1_vld || s1_take;

    // saturate loaded lengths to the code capacity
    assign load_len = (i_item.code_length > LEN_W'(CAP_BITS)) ? LEN_W'(CAP_BITS)
                                                              : i_item.code_length;

    // table writes happen at acceptance, so later reads see them
    always_comb begin
        tbl_wr.en   = in_accept && (i_item.op == OP_LOAD);
        tbl_wr.addr = i_item.symbol;
        tbl_wr.len  = load_len;
        tbl_wr.bits = i_item.code_bits;
    end

    hcbp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_item.symbol),
        .o_rd      (tbl_rd)
    );

    // lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_take) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op <= i_item.op;
        end
    end

    // keep only bits below the code length
    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            code_masked[i] = tbl_rd.bits[i] && (i < int'(tbl_rd.len));
        end
        code_ext = t_acc'(code_masked);
    end

    // packer: one action per cycle, full bytes drain before the next item
    always_comb begin
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        emit      = 1'b0;
        emit_byte = r_acc[BYTE_BITS-1:0];
        emit_err  = 1'b0;
        emit_last = 1'b0;
        s1_take   = 1'b0;
        if (r_cnt >= CNT_W'(BYTE_BITS)) begin
            if (out_free) begin
                emit      = 1'b1;
                emit_last = (r_cnt < CNT_W'(2 * BYTE_BITS));
                n_acc     = r_acc >> BYTE_BITS;
                n_cnt     = r_cnt - CNT_W'(BYTE_BITS);
            end
        end else if (r_s1_vld) begin
            case (r_s1_op)
                OP_ENCODE: begin
                    if (!tbl_rd.hit) begin
                        if (out_free) begin
                            emit      = 1'b1;
                            emit_byte = '0;
                            emit_err  = 1'b1;
                            emit_last = 1'b1;
                            s1_take   = 1'b1;
                        end
                    end else begin
                        s1_take = 1'b1;
                        n_acc   = r_acc | (code_ext << r_cnt[BPOS_W-1:0]);
                        n_cnt   = r_cnt + CNT_W'(tbl_rd.len);
                    end
                end
                OP_FLUSH: begin
                    if (r_cnt == '0) begin
                        s1_take = 1'b1;
                    end else if (out_free) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_acc     = '0;
                        n_cnt     = '0;
                        s1_take   = 1'b1;
                    end
                end
                default: begin
                    s1_take = 1'b1;
                end
            endcase
        end
    end

    // packer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_err  <= emit_err;
            r_out_last <= emit_last;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.out_byte = r_out_byte;
    assign o_res.error    = r_out_err;
    assign o_res.last     = r_out_last;

endmodule

// ===== rtl/core/hcbp_table.sv =====
// Per-symbol code table: length and code bits in a synchronous memory,
// valid marks in flip-flops cleared at reset. Depends on hcbp_pkg.
module hcbp_table import hcbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_wr          i_wr,
    input  logic             i_rd_en,
    input  logic [SYM_W-1:0] i_rd_addr,
    output t_tbl_rd          o_rd
);

    logic [LEN_W+CODE_W-1:0] r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic [LEN_W+CODE_W-1:0] r_rd_data;
    logic                    r_rd_hit;
    logic                    wr_in_range;
    logic                    rd_in_range;

    // symbols at or above the table depth have no entry
    assign wr_in_range = ({1'b0, i_wr.addr} < (SYM_W+1)'(SYMBOL_COUNT));
    assign rd_in_range = ({1'b0, i_rd_addr} < (SYM_W+1)'(SYMBOL_COUNT));

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in_range) begin
            r_mem[i_wr.addr[SYM_AW-1:0]] <= {i_wr.len, i_wr.bits};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr[SYM_AW-1:0]];
        end
    end

    // valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en && wr_in_range) begin
                r_valid[i_wr.addr[SYM_AW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= rd_in_range && r_valid[i_rd_addr[SYM_AW-1:0]];
            end
        end
    end

    assign o_rd.hit  = r_rd_hit;
    assign o_rd.len  = r_rd_data[LEN_W+CODE_W-1:CODE_W];
    assign o_rd.bits = r_rd_data[CODE_W-1:0];

endmodule

// ===== verif/huffman_code_bit_packer_tb.sv =====
// Testbench for huffman_code_bit_packer: directed and random load/encode/flush
// items, with a byte-level stream model checking every result transaction.
// Depends on hcbp_pkg, hcbp_if and the block itself.
module huffman_code_bit_packer_tb;
    import hcbp_pkg::*;

    // Op code that the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_LIMIT    = 5000;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 error;
        logic                 last;
    } t_byte_res;

    // Stream model: code table plus bit accumulator, and the bytes still owed
    class huffman_stream_model;
        logic [CODE_W-1:0]    code_word [SYMBOL_COUNT];
        logic [LEN_W-1:0]     code_len  [SYMBOL_COUNT];
        bit                   loaded    [SYMBOL_COUNT];
        logic [BYTE_BITS-1:0] acc_byte;
        int unsigned          acc_fill;
        t_byte_res            owed_bytes[$];
        int unsigned          mismatches;

        function new();
            foreach (loaded[i]) loaded[i] = 1'b0;
            acc_byte   = '0;
            acc_fill   = 0;
            mismatches = 0;
        endfunction

        function void push_byte(logic [BYTE_BITS-1:0] b, logic err);
            t_byte_res r;
            r.out_byte = b;
            r.error    = err;
            r.last     = 1'b0;
            owed_bytes.insert(owed_bytes.size(), r);
        endfunction

        // Note one accepted input transaction
        function void take_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
            int        before_cnt;
            int        tail;
            t_byte_res r;
            before_cnt = owed_bytes.size();
            case (op)
                OP_LOAD: begin
                    code_word[sym] = bits;
                    code_len[sym]  = (len > CAP_BITS) ? LEN_W'(CAP_BITS) : len;
                    loaded[sym]    = 1'b1;
                end
                OP_ENCODE: begin
                    if (!loaded[sym]) begin
                        // no code: error byte, accumulator untouched
                        push_byte('0, 1'b1);
                    end else begin
                        for (int i = 0; i < code_len[sym]; i++) begin
                            acc_byte[acc_fill] = code_word[sym][i];
                            acc_fill++;
                            if (acc_fill == BYTE_BITS) begin
                                push_byte(acc_byte, 1'b0);
                                acc_byte = '0;
                                acc_fill = 0;
                            end
                        end
                    end
                end
                OP_FLUSH: begin
                    if (acc_fill > 0) begin
                        push_byte(acc_byte, 1'b0);
                        acc_byte = '0;
                        acc_fill = 0;
                    end
                end
                default: ;
            endcase
            // last marks the final byte of this item
            if (owed_bytes.size() > before_cnt) begin
                tail             = owed_bytes.size() - 1;
                r                = owed_bytes[tail];
                r.last           = 1'b1;
                owed_bytes[tail] = r;
            end
        endfunction

        function void flag(string what, t_byte_res want, t_byte_res got);
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (%s): exp byte=%02h err=%0b last=%0b,",
                          " got byte=%02h err=%0b last=%0b"},
                         what, want.out_byte, want.error, want.last,
                         got.out_byte, got.error, got.last);
        endfunction

        // Check one accepted result transaction against the oldest owed byte
        function void check_byte(t_byte_res got);
            t_byte_res want;
            if (owed_bytes.size() == 0) begin
                want = '0;
                flag("unexpected result", want, got);
            end else begin
                want = owed_bytes.pop_front();
                if (got.out_byte !== want.out_byte) flag("out_byte", want, got);
                if (got.error !== want.error)       flag("error", want, got);
                if (got.last !== want.last)         flag("last", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hcbp_in_if  item_if ();
    hcbp_out_if res_if ();

    huffman_code_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_res   (res_if.source)
    );

    huffman_stream_model stream = new();

    logic [SYM_W-1:0] loaded_syms[$];
    int unsigned      items_sent;
    int unsigned      bytes_taken;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item after a random gap and wait for its transaction
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        int gap;
        gap = ((items_sent / 40) % 4 == 1) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.op          <= op;
        item_if.symbol      <= sym;
        item_if.code_length <= len;
        item_if.code_bits   <= bits;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        stream.take_item(op, sym, len, bits);
        if (op == OP_LOAD) loaded_syms.insert(loaded_syms.size(), sym);
        items_sent++;
    endtask

    // Random item: mostly encodes of loaded symbols, some loads, flushes, noise
    task automatic send_random_item(output bit counted);
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        sym  = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
        len  = LEN_W'($urandom);
        if (pick < 15) begin
            op = OP_LOAD;
            pick = $urandom_range(0, 9);
            // typical short codes, some long, a few needing saturation
            if (pick < 7)      len = LEN_W'($urandom_range(0, 12));
            else if (pick < 9) len = LEN_W'($urandom_range(13, CAP_BITS));
            else               len = LEN_W'($urandom_range(CAP_BITS + 1, (1 << LEN_W) - 1));
        end else if (pick < 82) begin
            op = OP_ENCODE;
            if (loaded_syms.size() > 0 && $urandom_range(0, 9) < 9)
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (pick < 94) begin
            op = OP_FLUSH;
        end else begin
            op = OP_UNUSED;
        end
        counted = (op != OP_UNUSED);
        send_item(op, sym, len, $urandom);
    endtask

    // Stimulus
    initial begin
        bit counted;
        int unsigned real_items;
        int unsigned drain;
        i_rst_n             <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.op          <= OP_LOAD;
        item_if.symbol      <= '0;
        item_if.code_length <= '0;
        item_if.code_bits   <= '0;
        items_sent = 0;
        real_items = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table edges, saturation, zero length, error and flush cases
        send_item(OP_ENCODE, 8'h00, '0, '0);               // unloaded symbol
        send_item(OP_FLUSH,  8'h00, '0, '0);               // nothing pending
        send_item(OP_UNUSED, 8'h11, 6'h3F, 32'hFFFF_FFFF); // ignored op
        send_item(OP_LOAD,   8'h00, 6'd0, 32'hDEAD_BEEF);  // zero-length code
        send_item(OP_ENCODE, 8'h00, '0, '0);
        send_item(OP_LOAD,   8'hFF, 6'd32, 32'hFFFF_FFFF);
        send_item(OP_ENCODE, 8'hFF, '0, '0);
        send_item(OP_LOAD,   8'h01, 6'd3, 32'h0000_0005);
        send_item(OP_ENCODE, 8'h01, '0, '0);
        send_item(OP_ENCODE, 8'hFF, '0, '0);
        send_item(OP_FLUSH,  8'h00, '0, '0);
        send_item(OP_LOAD,   8'h02, 6'h3F, 32'hA5A5_5A5A); // saturates
        send_item(OP_LOAD,   8'h03, 6'd33, 32'h0000_0000); // saturates
        send_item(OP_LOAD,   8'h04, 6'd7, 32'hFFFF_FF55);  // bits above length unused
        send_item(OP_ENCODE, 8'h04, '0, '0);               // seven bits pending
        send_item(OP_ENCODE, 8'h02, '0, '0);
        send_item(OP_ENCODE, 8'h03, '0, '0);
        send_item(OP_FLUSH,  8'h00, '0, '0);               // padded partial byte
        send_item(OP_LOAD,   8'h80, 6'd1, 32'h0000_0001);
        send_item(OP_ENCODE, 8'h80, '0, '0);
        send_item(OP_LOAD,   8'h00, 6'd8, 32'h0000_00C3);  // overwrite entry
        send_item(OP_ENCODE, 8'h00, '0, '0);
        send_item(OP_ENCODE, 8'h7F, '0, '0);               // unloaded, bits pending
        send_item(OP_FLUSH,  8'h00, '0, '0);
        send_item(OP_FLUSH,  8'h00, '0, '0);

        // Random
        while (real_items < RANDOM_ITEMS) begin
            send_random_item(counted);
            if (counted) real_items++;
        end
        send_item(OP_FLUSH, 8'h00, '0, '0);
        item_if.valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        drain = 0;
        while (stream.owed_bytes.size() > 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (stream.mismatches == 0 && stream.owed_bytes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: random stalls, idle-free stretches, one long hold-off
    initial begin
        int        stall;
        bit        held;
        t_byte_res got;
        held        = 1'b0;
        bytes_taken = 0;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = ((bytes_taken / 25) % 4 == 2) ? 0 : $urandom_range(0, 5);
            if (!held && bytes_taken == HOLD_AT_RESULT) begin
                // long hold-off so the block backs up into its input
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.out_byte = res_if.out_byte;
            got.error    = res_if.error;
            got.last     = res_if.last;
            stream.check_byte(got);
            bytes_taken++;
        end
    end

endmodule
